>>> rtl/tzop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tzop_pkg;

  // Character widths and result widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned ValueW  = 7;

  // Range limits of the offset
  localparam logic [ValueW-1:0] MaxHour   = 7'd14;
  localparam logic [ValueW-1:0] MaxMinute = 7'd59;

  // Seconds per hour and per minute
  localparam logic [OffsetW-1:0] SecPerHour = 17'd3600;
  localparam logic [OffsetW-1:0] SecPerMin  = 17'd60;

  // Syntax characters
  localparam logic [CharW-1:0] ChZulu  = 8'h5A;  // 'Z'
  localparam logic [CharW-1:0] ChColon = 8'h3A;  // ':'
  localparam logic [CharW-1:0] ChMinus = 8'h2D;  // '-'
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;  // '+'
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // Parser phases; the content of a signed offset is six characters long
  typedef enum logic [3:0] {
    PhLead  = 4'd0,
    PhZulu  = 4'd1,
    PhSign  = 4'd2,
    PhH1    = 4'd3,
    PhH2    = 4'd4,
    PhColon = 4'd5,
    PhM1    = 4'd6,
    PhM2    = 4'd7,
    PhTrail = 4'd8
  } phase_e;

  // Whitespace: space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_ws(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_dig(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

`default_nettype wire

>>> rtl/timezone_offset_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted final character passes through the input register, then into the output register.
// Throughput: one character per cycle unless held; the input and result registers part the sides.
// A final character waits in the input register only while an earlier result is not yet taken.
// Reset: asynchronous, active low; parser returns to the leading whitespace phase, both
// registers empty. After each final character the parser returns to that state by itself.
module timezone_offset_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // is_final
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [16:0] offset_seconds, [23:17] zero
  output logic             m_axis_tuser    // [0] valid_res
);

  localparam int unsigned VW = tzop_pkg::ValueW;
  localparam int unsigned OW = tzop_pkg::OffsetW;

  // Input register
  logic                       in_valid_q;
  logic [tzop_pkg::CharW-1:0] in_char_q;
  logic                       in_last_q;

  // Parser state
  tzop_pkg::phase_e phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [VW-1:0]    hour_q, hour_d;
  logic [VW-1:0]    min_q, min_d;
  logic             failed_q, failed_d;

  // Result register
  logic          out_valid_q;
  logic          out_ok_q;
  logic [OW-1:0] out_off_q;

  // Values after one character, before the end-of-string return to reset
  tzop_pkg::phase_e adv_phase;
  logic             adv_neg;
  logic [VW-1:0]    adv_hour;
  logic [VW-1:0]    adv_min;
  logic             adv_failed;
  logic [VW-1:0]    digit;

  logic          stage_go;
  logic          take;
  logic          res_ok;
  logic [OW-1:0] mag;
  logic [OW-1:0] res_off;

  // Hold a final character only while the previous result still waits
  assign stage_go      = !in_last_q || !out_valid_q || m_axis_tready;
  assign take          = in_valid_q && stage_go;
  assign s_axis_tready = !in_valid_q || stage_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign digit = {3'b000, in_char_q[3:0]};

  // Advance the parser by one character
  always_comb begin
    adv_phase  = phase_q;
    adv_neg    = neg_q;
    adv_hour   = hour_q;
    adv_min    = min_q;
    adv_failed = failed_q;
    if (!failed_q) begin
      unique case (phase_q)
        tzop_pkg::PhLead: begin
          if (tzop_pkg::is_ws(in_char_q)) begin
            adv_phase = tzop_pkg::PhLead;
          end else if (in_char_q == tzop_pkg::ChZulu) begin
            adv_phase = tzop_pkg::PhZulu;
          end else if (in_char_q == tzop_pkg::ChPlus) begin
            adv_neg   = 1'b0;
            adv_phase = tzop_pkg::PhSign;
          end else if (in_char_q == tzop_pkg::ChMinus) begin
            adv_neg   = 1'b1;
            adv_phase = tzop_pkg::PhSign;
          end else begin
            adv_failed = 1'b1;
          end
        end
        tzop_pkg::PhZulu, tzop_pkg::PhM2, tzop_pkg::PhTrail: begin
          if (tzop_pkg::is_ws(in_char_q)) adv_phase = tzop_pkg::PhTrail;
          else adv_failed = 1'b1;
        end
        tzop_pkg::PhSign: begin
          if (tzop_pkg::is_dig(in_char_q)) begin
            adv_hour  = digit;
            adv_phase = tzop_pkg::PhH1;
          end else begin
            adv_failed = 1'b1;
          end
        end
        tzop_pkg::PhH1: begin
          if (tzop_pkg::is_dig(in_char_q)) begin
            adv_hour  = VW'(hour_q * VW'(10)) + digit;
            adv_phase = tzop_pkg::PhH2;
          end else begin
            adv_failed = 1'b1;
          end
        end
        tzop_pkg::PhH2: begin
          if (in_char_q == tzop_pkg::ChColon) adv_phase = tzop_pkg::PhColon;
          else adv_failed = 1'b1;
        end
        tzop_pkg::PhColon: begin
          if (tzop_pkg::is_dig(in_char_q)) begin
            adv_min   = digit;
            adv_phase = tzop_pkg::PhM1;
          end else begin
            adv_failed = 1'b1;
          end
        end
        tzop_pkg::PhM1: begin
          if (tzop_pkg::is_dig(in_char_q)) begin
            adv_min   = VW'(min_q * VW'(10)) + digit;
            adv_phase = tzop_pkg::PhM2;
          end else begin
            adv_failed = 1'b1;
          end
        end
        default: adv_failed = 1'b1;
      endcase
    end
  end

  // Check content and range, then form the signed offset
  always_comb begin
    res_ok = !adv_failed
          && ((adv_phase == tzop_pkg::PhZulu) || (adv_phase == tzop_pkg::PhM2)
              || (adv_phase == tzop_pkg::PhTrail))
          && (adv_hour <= tzop_pkg::MaxHour) && (adv_min <= tzop_pkg::MaxMinute)
          && !((adv_hour == tzop_pkg::MaxHour) && (adv_min != '0));
    mag = OW'(OW'(adv_hour) * tzop_pkg::SecPerHour)
        + OW'(OW'(adv_min) * tzop_pkg::SecPerMin);
    if (!res_ok)     res_off = '0;
    else if (adv_neg) res_off = OW'(-mag);
    else             res_off = mag;
  end

  // Return to reset after the final character
  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    hour_d   = hour_q;
    min_d    = min_q;
    failed_d = failed_q;
    if (take) begin
      if (in_last_q) begin
        phase_d  = tzop_pkg::PhLead;
        neg_d    = 1'b0;
        hour_d   = '0;
        min_d    = '0;
        failed_d = 1'b0;
      end else begin
        phase_d  = adv_phase;
        neg_d    = adv_neg;
        hour_d   = adv_hour;
        min_d    = adv_min;
        failed_d = adv_failed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tzop_pkg::PhLead;
      neg_q    <= 1'b0;
      hour_q   <= '0;
      min_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      hour_q   <= hour_d;
      min_q    <= min_d;
      failed_q <= failed_d;
    end
  end

  // Load the result on a final character, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_last_q) begin
      out_ok_q  <= res_ok;
      out_off_q <= res_off;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, out_off_q};
  assign m_axis_tuser  = out_ok_q;

endmodule

`default_nettype wire

>>> tb/tb_timezone_offset_parser_unit.sv
`timescale 1ns / 1ps

module tb_timezone_offset_parser_unit;

  // One character of a timezone string and one parse result
  typedef struct packed {
    logic [tzop_pkg::CharW-1:0] code;
    logic                       fin;
  } tz_char_t;

  typedef struct packed {
    logic                         ok;
    logic [tzop_pkg::OffsetW-1:0] secs;
  } tz_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  wire                        s_axis_tready;
  logic [tzop_pkg::CharW-1:0] s_axis_tdata  = '0;
  logic                       s_axis_tlast  = 1'b0;
  wire                        m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  wire  [23:0]                m_axis_tdata;
  wire                        m_axis_tuser;

  timezone_offset_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Characters waiting to be sent, results waiting to arrive
  tz_char_t                   char_q[$];
  tz_result_t                 offset_q[$];
  logic [tzop_pkg::CharW-1:0] txt[$];
  int unsigned                n_chars    = 0;
  int unsigned                fail_count = 0;

  // Parser state mirrored by the testbench
  tzop_pkg::phase_e            tz_phase  = tzop_pkg::PhLead;
  logic                        tz_neg    = 1'b0;
  logic [tzop_pkg::ValueW-1:0] tz_hours  = '0;
  logic [tzop_pkg::ValueW-1:0] tz_mins   = '0;
  logic                        tz_broken = 1'b0;

  function automatic logic blank_char(input logic [tzop_pkg::CharW-1:0] c);
    return (c == tzop_pkg::ChSpace) || ((c >= tzop_pkg::ChTab) && (c <= tzop_pkg::ChCr));
  endfunction

  function automatic logic digit_char(input logic [tzop_pkg::CharW-1:0] c);
    return (c >= tzop_pkg::ChZero) && (c <= tzop_pkg::ChNine);
  endfunction

  // Advance the parser by one character; on the final one, queue the offset
  task automatic parse_char(input logic [tzop_pkg::CharW-1:0] c, input logic fin);
    logic [tzop_pkg::ValueW-1:0]  d;
    logic                         ok;
    logic [tzop_pkg::OffsetW-1:0] mag;
    tz_result_t                   r;
    d = tzop_pkg::ValueW'(c - tzop_pkg::ChZero);
    if (!tz_broken) begin
      case (tz_phase)
        tzop_pkg::PhLead: begin
          if (blank_char(c)) begin
          end else if (c == tzop_pkg::ChZulu) begin
            tz_phase = tzop_pkg::PhZulu;
          end else if (c == tzop_pkg::ChPlus) begin
            tz_neg   = 1'b0;
            tz_phase = tzop_pkg::PhSign;
          end else if (c == tzop_pkg::ChMinus) begin
            tz_neg   = 1'b1;
            tz_phase = tzop_pkg::PhSign;
          end else begin
            tz_broken = 1'b1;
          end
        end
        tzop_pkg::PhZulu, tzop_pkg::PhM2, tzop_pkg::PhTrail: begin
          if (blank_char(c)) tz_phase = tzop_pkg::PhTrail;
          else tz_broken = 1'b1;
        end
        tzop_pkg::PhSign: begin
          if (digit_char(c)) begin
            tz_hours = d;
            tz_phase = tzop_pkg::PhH1;
          end else tz_broken = 1'b1;
        end
        tzop_pkg::PhH1: begin
          if (digit_char(c)) begin
            tz_hours = tzop_pkg::ValueW'(tz_hours * 10 + d);
            tz_phase = tzop_pkg::PhH2;
          end else tz_broken = 1'b1;
        end
        tzop_pkg::PhH2: begin
          if (c == tzop_pkg::ChColon) tz_phase = tzop_pkg::PhColon;
          else tz_broken = 1'b1;
        end
        tzop_pkg::PhColon: begin
          if (digit_char(c)) begin
            tz_mins  = d;
            tz_phase = tzop_pkg::PhM1;
          end else tz_broken = 1'b1;
        end
        tzop_pkg::PhM1: begin
          if (digit_char(c)) begin
            tz_mins  = tzop_pkg::ValueW'(tz_mins * 10 + d);
            tz_phase = tzop_pkg::PhM2;
          end else tz_broken = 1'b1;
        end
        default: tz_broken = 1'b1;
      endcase
    end
    if (fin) begin
      ok = !tz_broken
           && (tz_phase == tzop_pkg::PhZulu || tz_phase == tzop_pkg::PhM2
               || tz_phase == tzop_pkg::PhTrail)
           && tz_hours <= tzop_pkg::MaxHour && tz_mins <= tzop_pkg::MaxMinute
           && !(tz_hours == tzop_pkg::MaxHour && tz_mins != 0);
      mag    = tz_hours * tzop_pkg::SecPerHour + tz_mins * tzop_pkg::SecPerMin;
      r.ok   = ok;
      r.secs = !ok ? '0 : (tz_neg ? -mag : mag);
      offset_q.push_back(r);
      tz_phase  = tzop_pkg::PhLead;
      tz_neg    = 1'b0;
      tz_hours  = '0;
      tz_mins   = '0;
      tz_broken = 1'b0;
    end
  endtask

  // Idle length per request, with occasional runs of back-to-back requests
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  // Build strings in txt, then move them to the send queue
  task automatic put_byte(input logic [tzop_pkg::CharW-1:0] b);
    txt.push_back(b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_blanks(input int unsigned n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 5);
      put_byte(k == 0 ? tzop_pkg::ChSpace : tzop_pkg::CharW'(tzop_pkg::ChTab + k - 1));
    end
  endtask

  task automatic put_offset();
    int unsigned hh;
    int unsigned mm;
    hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 15);
    mm = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    if (hh == 14 && $urandom_range(0, 1) == 0) mm = 0;
    put_byte($urandom_range(0, 1) ? tzop_pkg::ChMinus : tzop_pkg::ChPlus);
    put_byte(tzop_pkg::CharW'(tzop_pkg::ChZero + hh / 10));
    put_byte(tzop_pkg::CharW'(tzop_pkg::ChZero + hh % 10));
    put_byte(tzop_pkg::ChColon);
    put_byte(tzop_pkg::CharW'(tzop_pkg::ChZero + mm / 10));
    put_byte(tzop_pkg::CharW'(tzop_pkg::ChZero + mm % 10));
  endtask

  task automatic commit_text();
    tz_char_t ch;
    for (int i = 0; i < txt.size(); i++) begin
      ch.code = txt[i];
      ch.fin  = (i == txt.size() - 1);
      char_q.push_back(ch);
    end
    n_chars += txt.size();
    txt.delete();
  endtask

  // Send side: hold each request until taken, then idle for a drawn gap
  tz_char_t    next_char;
  logic        char_offered = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned send_calm    = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      char_offered  = 1'b0;
      send_gap      = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, s_axis_tlast);
        char_offered = 1'b0;
        send_gap     = draw_gap(send_calm);
      end
      if (!char_offered) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (char_q.size() != 0) begin
          next_char = char_q.pop_front();
          s_axis_tdata <= next_char.code;
          s_axis_tlast <= next_char.fin;
          char_offered = 1'b1;
        end
      end
      s_axis_tvalid <= char_offered;
    end
  end

  // Compare one result against the oldest queued offset
  task automatic check_result();
    tz_result_t want;
    if (offset_q.size() == 0) begin
      $error("result with no string pending: valid_res %0b offset_seconds %0d",
             m_axis_tuser, $signed(m_axis_tdata[tzop_pkg::OffsetW-1:0]));
      fail_count++;
    end else begin
      want = offset_q.pop_front();
      if (m_axis_tuser !== want.ok) begin
        $error("valid_res: expected %0b, got %0b", want.ok, m_axis_tuser);
        fail_count++;
      end
      if (m_axis_tdata[tzop_pkg::OffsetW-1:0] !== want.secs) begin
        $error("offset_seconds: expected %0d, got %0d",
               $signed(want.secs), $signed(m_axis_tdata[tzop_pkg::OffsetW-1:0]));
        fail_count++;
      end
      if (m_axis_tdata[23:tzop_pkg::OffsetW] !== '0) begin
        $error("tdata padding: expected 0, got %0h", m_axis_tdata[23:tzop_pkg::OffsetW]);
        fail_count++;
      end
    end
  endtask

  // Receive side: drop ready for a drawn gap after each result
  int unsigned take_gap  = 0;
  int unsigned take_calm = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_gap      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        take_gap = draw_gap(take_calm);
      end
      if (take_gap != 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned kind;
    int unsigned cut;
    int unsigned idx;

    // Zulu between tab and carriage return
    put_str("\011Z\015");
    commit_text();
    // Negative zero
    put_str("-00:00");
    commit_text();
    // Fourteen hours with non-zero minutes, trailing space
    put_str("+14:01 ");
    commit_text();
    // Whitespace only
    put_str(" ");
    commit_text();
    // Whitespace after content that is too short
    put_str("+1 ");
    commit_text();
    // Extra content after Zulu
    put_str("Z5");
    commit_text();
    // Byte above 127, then the zero byte
    put_byte(8'hFF);
    commit_text();
    put_byte(8'h00);
    commit_text();

    while (n_chars < 1024) begin
      kind = $urandom_range(0, 99);
      put_blanks($urandom_range(0, 2));
      if (kind < 50) begin
        put_offset();
      end else if (kind < 60) begin
        put_byte(tzop_pkg::ChZulu);
      end else if (kind < 85) begin
        put_offset();
        case ($urandom_range(0, 2))
          0: begin
            idx      = $urandom_range(0, txt.size() - 1);
            txt[idx] = tzop_pkg::CharW'($urandom_range(0, 255));
          end
          1: begin
            cut = $urandom_range(1, 5);
            repeat (cut) void'(txt.pop_back());
          end
          default: begin
            idx = $urandom_range(0, txt.size());
            txt.insert(idx, tzop_pkg::ChSpace);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 8)) put_byte(tzop_pkg::CharW'($urandom_range(0, 255)));
      end
      put_blanks($urandom_range(0, 2));
      commit_text();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait on settled values only
    @(negedge clk_i);
    while (char_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (offset_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #400us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/tzop_pkg.sv
rtl/timezone_offset_parser_unit.sv
tb/tb_timezone_offset_parser_unit.sv
